// ===== rtl/core/ncl_pkg.sv =====
`timescale 1ns / 1ps
package ncl_pkg;

	typedef enum logic {
		OP_CLASSIFY = 1'b0,
		OP_LOAD     = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_CLUSTERS_IN_USE  = 2'd0,
		REG_INCLUDE_POSITION = 2'd1,
		REG_SPARE_2          = 2'd2,
		REG_SPARE_3          = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} colour_t;

	typedef struct packed {
		op_t        op;
		logic       is_bg;
		logic [2:0] slot;
	} item_ctrl_t;

endpackage

// ===== rtl/core/ncl_ram.sv =====
`timescale 1ns / 1ps
module ncl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/ncl_front.sv =====
`timescale 1ns / 1ps
module ncl_front #(
	parameter int MAX_CLUSTERS  = 8,
	parameter int POSITION_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ncl_pkg::item_ctrl_t       in_ctrl,
	input  ncl_pkg::colour_t          in_rgb,
	input  logic [11:0]               in_row,
	input  logic [11:0]               in_col,
	output logic                      q_valid,
	input  logic                      q_pop,
	output ncl_pkg::item_ctrl_t       q_ctrl,
	output ncl_pkg::colour_t          q_rgb,
	output logic [POSITION_BITS-1:0]  q_row,
	output logic [POSITION_BITS-1:0]  q_col
);
	import ncl_pkg::*;

	item_ctrl_t               ctrl_q [2];
	colour_t                  rgb_q  [2];
	logic [POSITION_BITS-1:0] row_q  [2];
	logic [POSITION_BITS-1:0] col_q  [2];
	logic                     wp_q;
	logic                     rp_q;
	logic [1:0]               fill_q;

	logic [POSITION_BITS+11:0] row_ext;
	logic [POSITION_BITS+11:0] col_ext;
	logic                      accept;
	logic                      drop;
	logic                      push;
	logic                      pop;

	assign row_ext  = {{POSITION_BITS{1'b0}}, in_row};
	assign col_ext  = {{POSITION_BITS{1'b0}}, in_col};
	assign in_ready = (fill_q != 2'd2);
	assign accept   = in_valid && in_ready;
	// loads aimed past the table are discarded here
	assign drop     = (in_ctrl.op == OP_LOAD) && (32'(in_ctrl.slot) >= MAX_CLUSTERS);
	assign push     = accept && !drop;
	assign pop      = q_pop && q_valid;

	assign q_valid = (fill_q != 2'd0);
	assign q_ctrl  = ctrl_q[rp_q];
	assign q_rgb   = rgb_q[rp_q];
	assign q_row   = row_q[rp_q];
	assign q_col   = col_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wp_q] <= in_ctrl;
			rgb_q[wp_q]  <= in_rgb;
			row_q[wp_q]  <= row_ext[POSITION_BITS-1:0];
			col_q[wp_q]  <= col_ext[POSITION_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/ncl_back.sv =====
`timescale 1ns / 1ps
module ncl_back #(
	parameter int MAX_CLUSTERS  = 8,
	parameter int POSITION_BITS = 12,
	parameter int FRACTION_BITS = 16,
	localparam int CNTW = $clog2(MAX_CLUSTERS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CNTW-1:0]           count,
	input  logic                      include_position,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  ncl_pkg::item_ctrl_t       q_ctrl,
	input  ncl_pkg::colour_t          q_rgb,
	input  logic [POSITION_BITS-1:0]  q_row,
	input  logic [POSITION_BITS-1:0]  q_col,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [15:0]               fg_cost,
	output logic [15:0]               bg_cost,
	output logic                      degenerate
);
	import ncl_pkg::*;

	localparam int PB    = POSITION_BITS;
	localparam int FB    = FRACTION_BITS;
	localparam int DEPTH = 2 * MAX_CLUSTERS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int EW    = 24 + 2 * PB;
	localparam int DW    = ((2 * PB + 1 > 18) ? (2 * PB + 1) : 18) + 1;
	localparam int SW    = DW + 1;
	localparam int QW    = FB + 1;
	localparam int NW    = SW + FB;
	localparam int BW    = $clog2(QW);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_WAIT = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	colour_t         pix_rgb_q;
	logic [PB-1:0]   pix_row_q;
	logic [PB-1:0]   pix_col_q;
	logic            set_q;
	logic [KW-1:0]   k_q;

	logic            v_s1;
	logic            set_s1;
	logic            first_s1;
	logic            v_s2;
	logic            set_s2;
	logic            first_s2;
	logic [15:0]     sqr_s2;
	logic [15:0]     sqg_s2;
	logic [15:0]     sqb_s2;
	logic [2*PB-1:0] sqrow_s2;
	logic [2*PB-1:0] sqcol_s2;

	logic [DW-1:0]   df_q;
	logic [DW-1:0]   db_q;
	logic [SW-1:0]   sum_q;
	logic [SW-1:0]   remf_q;
	logic [SW-1:0]   remb_q;
	logic [QW-1:0]   nlof_q;
	logic [QW-1:0]   nlob_q;
	logic [QW-1:0]   qf_q;
	logic [QW-1:0]   qb_q;
	logic [BW-1:0]   bit_q;
	logic            degen_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic            re;
	logic [AW-1:0]   raddr;
	logic [EW-1:0]   rdata;
	logic [EW-1:0]   wdata;

	logic [7:0]      e_r;
	logic [7:0]      e_g;
	logic [7:0]      e_b;
	logic [PB-1:0]   e_row;
	logic [PB-1:0]   e_col;
	logic [7:0]      ad_r;
	logic [7:0]      ad_g;
	logic [7:0]      ad_b;
	logic [PB-1:0]   ad_row;
	logic [PB-1:0]   ad_col;
	logic [DW-1:0]   dist_c;
	logic            last_issue;

	logic [SW-1:0]   sum_c;
	logic [NW-1:0]   nf_c;
	logic [NW-1:0]   nb_c;
	logic [SW:0]     tf;
	logic [SW:0]     tb;
	logic            gef;
	logic            geb;
	logic [FB-1:0]   resf;
	logic [FB-1:0]   resb;
	logic [FB+15:0]  extf;
	logic [FB+15:0]  extb;

	assign wdata = {q_rgb.r, q_rgb.g, q_rgb.b, q_row, q_col};
	assign waddr = q_ctrl.is_bg ? (AW'(MAX_CLUSTERS) + AW'(q_ctrl.slot)) : AW'(q_ctrl.slot);
	assign we    = (state_q == S_IDLE) && q_valid && (q_ctrl.op == OP_LOAD);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign re    = (state_q == S_WALK);
	assign raddr = set_q ? (AW'(MAX_CLUSTERS) + AW'(k_q)) : AW'(k_q);
	assign last_issue = (32'(k_q) + 32'd1 == 32'(count));

	ncl_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign {e_r, e_g, e_b, e_row, e_col} = rdata;
	assign ad_r   = (e_r > pix_rgb_q.r) ? (e_r - pix_rgb_q.r) : (pix_rgb_q.r - e_r);
	assign ad_g   = (e_g > pix_rgb_q.g) ? (e_g - pix_rgb_q.g) : (pix_rgb_q.g - e_g);
	assign ad_b   = (e_b > pix_rgb_q.b) ? (e_b - pix_rgb_q.b) : (pix_rgb_q.b - e_b);
	assign ad_row = (e_row > pix_row_q) ? (e_row - pix_row_q) : (pix_row_q - e_row);
	assign ad_col = (e_col > pix_col_q) ? (e_col - pix_col_q) : (pix_col_q - e_col);

	assign dist_c = DW'(sqr_s2) + DW'(sqg_s2) + DW'(sqb_s2)
		+ (include_position ? (DW'(sqrow_s2) + DW'(sqcol_s2)) : DW'(0));

	assign sum_c = SW'(df_q) + SW'(db_q);
	assign nf_c  = {NW'(df_q) << FB} + NW'(sum_c >> 1);
	assign nb_c  = {NW'(db_q) << FB} + NW'(sum_c >> 1);

	assign tf  = {remf_q, nlof_q[QW-1]};
	assign tb  = {remb_q, nlob_q[QW-1]};
	assign gef = (tf >= {1'b0, sum_q});
	assign geb = (tb >= {1'b0, sum_q});

	assign resf = qf_q[FB] ? {FB{1'b1}} : qf_q[FB-1:0];
	assign resb = qb_q[FB] ? {FB{1'b1}} : qb_q[FB-1:0];
	assign extf = {16'd0, resf};
	assign extb = {16'd0, resb};

	// distance pipeline: table read, squares, sum and running minimum
	always_ff @(posedge clk) begin
		sqr_s2   <= 16'(ad_r) * 16'(ad_r);
		sqg_s2   <= 16'(ad_g) * 16'(ad_g);
		sqb_s2   <= 16'(ad_b) * 16'(ad_b);
		sqrow_s2 <= (2*PB)'(ad_row) * (2*PB)'(ad_row);
		sqcol_s2 <= (2*PB)'(ad_col) * (2*PB)'(ad_col);
		set_s1   <= set_q;
		first_s1 <= (k_q == KW'(0));
		set_s2   <= set_s1;
		first_s2 <= first_s1;
		if (v_s2) begin
			if (set_s2) begin
				if (first_s2 || dist_c < db_q) begin
					db_q <= dist_c;
				end
			end else begin
				if (first_s2 || dist_c < df_q) begin
					df_q <= dist_c;
				end
			end
		end
		if (state_q == S_IDLE && q_valid && q_ctrl.op == OP_CLASSIFY) begin
			pix_rgb_q <= q_rgb;
			pix_row_q <= q_row;
			pix_col_q <= q_col;
		end
		if (state_q == S_WAIT) begin
			sum_q   <= sum_c;
			remf_q  <= SW'(nf_c[NW-1:QW]);
			remb_q  <= SW'(nb_c[NW-1:QW]);
			nlof_q  <= nf_c[QW-1:0];
			nlob_q  <= nb_c[QW-1:0];
			degen_q <= (sum_c == SW'(0));
			qf_q    <= QW'(1) << (FB - 1);
			qb_q    <= QW'(1) << (FB - 1);
		end
		if (state_q == S_DIV) begin
			remf_q <= gef ? SW'(tf - {1'b0, sum_q}) : tf[SW-1:0];
			remb_q <= geb ? SW'(tb - {1'b0, sum_q}) : tb[SW-1:0];
			nlof_q <= nlof_q << 1;
			nlob_q <= nlob_q << 1;
			qf_q   <= {qf_q[QW-2:0], gef};
			qb_q   <= {qb_q[QW-2:0], geb};
		end
		if (state_q == S_FIN && (!out_valid || out_ready)) begin
			fg_cost    <= extf[15:0];
			bg_cost    <= extb[15:0];
			degenerate <= degen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			set_q     <= 1'b0;
			k_q       <= '0;
			bit_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= re;
			v_s2 <= v_s1;
			if (state_q == S_FIN && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_ctrl.op == OP_CLASSIFY) begin
						set_q   <= 1'b0;
						k_q     <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (last_issue) begin
						k_q <= '0;
						if (set_q) begin
							state_q <= S_WAIT;
						end else begin
							set_q <= 1'b1;
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_WAIT: begin
					if (!v_s1 && !v_s2) begin
						bit_q   <= '0;
						state_q <= (sum_c == SW'(0)) ? S_FIN : S_DIV;
					end
				end
				S_DIV: begin
					if (bit_q == BW'(QW - 1)) begin
						state_q <= S_FIN;
					end else begin
						bit_q <= bit_q + BW'(1);
					end
				end
				S_FIN: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/nearest_cluster_likelihood.sv =====
`timescale 1ns / 1ps
// nearest-cluster likelihood unit
// input channel (in_valid/in_ready): operation 1 loads one center (set, slot,
// colour, position) into the center table, operation 0 classifies a pixel
// output channel (out_valid/out_ready): one transfer per classify item with
// fg_cost, bg_cost in Q0.FRACTION_BITS and the degenerate flag
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register 0
// clusters_in_use, register 1 include_position; always ready
// a two-entry queue sits between the input and the sequencer
// load: written into the table while the sequencer stays idle
// classify: pop the queue, 2*N table reads (N centers in use, one per
// cycle), pipeline drain, radix-2 division for FRACTION_BITS+1 quotient
// bits, then the output register; a degenerate pixel skips the division
// reset clears the queue, the sequencer and out_valid; table contents are
// undefined until loaded; clusters_in_use resets to 8, include_position to 0
// a stalled receiver holds the result in the output register; the queue
// keeps accepting until full
module nearest_cluster_likelihood #(
	parameter int MAX_CLUSTERS  = 8,
	parameter int POSITION_BITS = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic        is_background,
	input  logic [2:0]  slot,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [11:0] row,
	input  logic [11:0] col,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] fg_cost,
	output logic [15:0] bg_cost,
	output logic        degenerate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import ncl_pkg::*;

	localparam int CNTW = $clog2(MAX_CLUSTERS + 1);

	logic [3:0]               clusters_q;
	logic                     incpos_q;
	logic [CNTW-1:0]          count;
	item_ctrl_t               in_ctrl;
	colour_t                  in_rgb;
	logic                     q_valid;
	logic                     q_pop;
	item_ctrl_t               q_ctrl;
	colour_t                  q_rgb;
	logic [POSITION_BITS-1:0] q_row;
	logic [POSITION_BITS-1:0] q_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= 4'd8;
			incpos_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CLUSTERS_IN_USE:  clusters_q <= cfg_data;
				REG_INCLUDE_POSITION: incpos_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (clusters_q == 4'd0) begin
			count = CNTW'(1);
		end else if (32'(clusters_q) > MAX_CLUSTERS) begin
			count = CNTW'(MAX_CLUSTERS);
		end else begin
			count = CNTW'(clusters_q);
		end
	end

	assign in_ctrl = '{op: op_t'(operation), is_bg: is_background, slot: slot};
	assign in_rgb  = '{r: red, g: green, b: blue};

	ncl_front #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_ctrl (in_ctrl),
		.in_rgb  (in_rgb),
		.in_row  (row),
		.in_col  (col),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_ctrl  (q_ctrl),
		.q_rgb   (q_rgb),
		.q_row   (q_row),
		.q_col   (q_col)
	);

	ncl_back #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.POSITION_BITS(POSITION_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.count           (count),
		.include_position(incpos_q),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_ctrl          (q_ctrl),
		.q_rgb           (q_rgb),
		.q_row           (q_row),
		.q_col           (q_col),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.fg_cost         (fg_cost),
		.bg_cost         (bg_cost),
		.degenerate      (degenerate)
	);

endmodule

// ===== tb/tb_nearest_cluster_likelihood.sv =====
`timescale 1ns / 1ps
module tb_nearest_cluster_likelihood;
	import ncl_pkg::*;

	typedef struct {
		logic [15:0] fg;
		logic [15:0] bg;
		logic        deg;
	} cost_t;

	typedef struct {
		op_t         op;
		logic        bg_set;
		logic [2:0]  sl;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [11:0] y;
		logic [11:0] x;
		logic        typed;
		cost_t       want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic        is_background;
	logic [2:0]  slot;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [11:0] row;
	logic [11:0] col;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] fg_cost;
	logic [15:0] bg_cost;
	logic        degenerate;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	// own copy of the center table and registers
	logic [7:0]  ctr_r [16];
	logic [7:0]  ctr_g [16];
	logic [7:0]  ctr_b [16];
	logic [11:0] ctr_y [16];
	logic [11:0] ctr_x [16];
	logic [3:0]  cnt_reg;
	logic        pos_reg;

	cost_t pending_costs[$];
	row_t  directed[$];
	int    errors;
	int    stall_mode;

	nearest_cluster_likelihood dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .is_background(is_background), .slot(slot),
		.red(red), .green(green), .blue(blue), .row(row), .col(col),
		.out_valid(out_valid), .out_ready(out_ready),
		.fg_cost(fg_cost), .bg_cost(bg_cost), .degenerate(degenerate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint unsigned sq_gap(int a, int b);
		longint d;
		d = a - b;
		return d * d;
	endfunction

	function automatic longint unsigned nearest_dist(int base, int n, row_t p);
		longint unsigned best;
		longint unsigned d;
		best = 0;
		for (int i = 0; i < n; i++) begin
			d = sq_gap(ctr_r[base+i], p.r) + sq_gap(ctr_g[base+i], p.g)
				+ sq_gap(ctr_b[base+i], p.b);
			if (pos_reg)
				d += sq_gap(ctr_y[base+i], p.y) + sq_gap(ctr_x[base+i], p.x);
			if (i == 0 || d < best)
				best = d;
		end
		return best;
	endfunction

	function automatic logic [15:0] q16_ratio(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = ((num << 16) + (den >> 1)) / den;
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic cost_t cost_of(row_t p);
		cost_t c;
		int n;
		longint unsigned df;
		longint unsigned db;
		n = (cnt_reg == 0) ? 1 : ((cnt_reg > 8) ? 8 : cnt_reg);
		df = nearest_dist(0, n, p);
		db = nearest_dist(8, n, p);
		c.deg = (df + db == 0);
		if (c.deg) begin
			c.fg = 16'h8000;
			c.bg = 16'h8000;
		end else begin
			c.fg = q16_ratio(df, df + db);
			c.bg = q16_ratio(db, df + db);
		end
		return c;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] exp_v);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
		errors++;
	endtask

	task automatic add_row(row_t it);
		directed.insert(directed.size(), it);
	endtask

	// drive at the current edge, return at the edge of the transfer
	task automatic send(row_t it);
		in_valid      <= 1'b1;
		operation     <= it.op;
		is_background <= it.bg_set;
		slot          <= it.sl;
		red           <= it.r;
		green         <= it.g;
		blue          <= it.b;
		row           <= it.y;
		col           <= it.x;
		do @(posedge clk); while (!in_ready);
		if (it.op == OP_LOAD) begin
			ctr_r[{it.bg_set, it.sl}] = it.r;
			ctr_g[{it.bg_set, it.sl}] = it.g;
			ctr_b[{it.bg_set, it.sl}] = it.b;
			ctr_y[{it.bg_set, it.sl}] = it.y;
			ctr_x[{it.bg_set, it.sl}] = it.x;
		end else if (it.typed) begin
			pending_costs.insert(pending_costs.size(), it.want);
		end else begin
			pending_costs.insert(pending_costs.size(), cost_of(it));
		end
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_costs.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_CLUSTERS_IN_USE)
			cnt_reg = val;
		else if (idx == REG_INCLUDE_POSITION)
			pos_reg = val[0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic row_t mk(op_t op, logic s, logic [2:0] sl, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [11:0] y, logic [11:0] x);
		row_t it;
		it.op = op; it.bg_set = s; it.sl = sl;
		it.r = r; it.g = g; it.b = b; it.y = y; it.x = x;
		it.typed = 1'b0;
		it.want = '{16'd0, 16'd0, 1'b0};
		return it;
	endfunction

	function automatic row_t typed_row(row_t it, logic [15:0] f, logic [15:0] b, logic d);
		it.typed = 1'b1;
		it.want = '{f, b, d};
		return it;
	endfunction

	function automatic logic [11:0] rand_pos();
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic row_t rand_item();
		row_t it;
		int k;
		it = mk(OP_CLASSIFY, $urandom_range(0, 1), $urandom_range(0, 7),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			rand_pos(), rand_pos());
		if ($urandom_range(0, 99) < 15) begin
			it.op = OP_LOAD;
			// twin centers make degenerate pixels reachable
			if ($urandom_range(0, 3) == 0) begin
				k = {~it.bg_set, it.sl};
				it.r = ctr_r[k]; it.g = ctr_g[k]; it.b = ctr_b[k];
				it.y = ctr_y[k]; it.x = ctr_x[k];
			end
		end else if ($urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, 15);
			it.r = ctr_r[k]; it.g = ctr_g[k]; it.b = ctr_b[k];
			it.y = ctr_y[k]; it.x = ctr_x[k];
			if ($urandom_range(0, 1))
				it.r = it.r + $urandom_range(0, 3);
		end
		return it;
	endfunction

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	always @(posedge clk) begin
		cost_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_costs.size() == 0) begin
				report("unexpected transfer fg_cost", fg_cost, 16'd0);
			end else begin
				e = pending_costs.pop_front();
				if (fg_cost !== e.fg)
					report("fg_cost", fg_cost, e.fg);
				if (bg_cost !== e.bg)
					report("bg_cost", bg_cost, e.bg);
				if (degenerate !== e.deg)
					report("degenerate", degenerate, e.deg);
			end
		end
	end

	initial begin
		row_t it;
		int sent;
		int burst;
		int phase_n;
		logic [3:0] cnt_list[7];
		logic       pos_list[7];
		errors = 0;
		stall_mode = 0;
		cnt_reg = 4'd8;
		pos_reg = 1'b0;
		in_valid = 1'b0; operation = 1'b0; is_background = 1'b0; slot = '0;
		red = '0; green = '0; blue = '0; row = '0; col = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		for (int i = 0; i < 16; i++) begin
			ctr_r[i] = '0; ctr_g[i] = '0; ctr_b[i] = '0; ctr_y[i] = '0; ctr_x[i] = '0;
		end
		cnt_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
		pos_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: one center per set
		write_reg(REG_CLUSTERS_IN_USE, 4'd1);
		write_reg(REG_INCLUDE_POSITION, 1'b1);
		add_row(mk(OP_LOAD, 1'b0, 3'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0));
		add_row(mk(OP_LOAD, 1'b1, 3'd0, 8'd255, 8'd255, 8'd255,
			12'hFFF, 12'hFFF));
		add_row(typed_row(mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd0, 8'd0, 8'd0,
			12'd0, 12'd0), 16'd0, 16'hFFFF, 1'b0));
		add_row(typed_row(mk(OP_CLASSIFY, 1'b1, 3'd7, 8'd255, 8'd255, 8'd255,
			12'hFFF, 12'hFFF), 16'hFFFF, 16'd0, 1'b0));
		add_row(mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd255, 8'd0, 8'd255,
			12'd0, 12'hFFF));
		add_row(mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd128, 8'd128, 8'd128,
			12'd2048, 12'd2048));
		add_row(mk(OP_LOAD, 1'b1, 3'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0));
		add_row(typed_row(mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd0, 8'd0, 8'd0,
			12'd0, 12'd0), 16'h8000, 16'h8000, 1'b1));
		add_row(mk(OP_LOAD, 1'b0, 3'd0, 8'd10, 8'd20, 8'd30, 12'd100, 12'd200));
		add_row(mk(OP_LOAD, 1'b1, 3'd0, 8'd10, 8'd20, 8'd30, 12'd100, 12'd210));
		add_row(typed_row(mk(OP_CLASSIFY, 1'b1, 3'd5, 8'd10, 8'd20, 8'd30,
			12'd100, 12'd200), 16'd0, 16'hFFFF, 1'b0));
		add_row(mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd10, 8'd20, 8'd30, 12'd100, 12'd205));
		add_row(mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd11, 8'd20, 8'd30, 12'd100, 12'd207));
		add_row(mk(OP_LOAD, 1'b1, 3'd7, 8'd1, 8'd2, 8'd3, 12'd4, 12'd5));
		foreach (directed[i]) begin
			send(directed[i]);
			pause($urandom_range(0, 2));
		end
		drain();
		write_reg(REG_INCLUDE_POSITION, 1'b0);
		it = mk(OP_CLASSIFY, 1'b0, 3'd0, 8'd10, 8'd20, 8'd30, 12'd0, 12'd0);
		send(typed_row(it, 16'h8000, 16'h8000, 1'b1));

		// fill every center before wider counts are used
		for (int i = 0; i < 16; i++) begin
			it = mk(OP_LOAD, i[3], i[2:0], $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), rand_pos(), rand_pos());
			send(it);
			pause($urandom_range(0, 1));
		end

		sent = 0;
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			write_reg(REG_CLUSTERS_IN_USE, cnt_list[ph]);
			write_reg(REG_INCLUDE_POSITION, pos_list[ph]);
			phase_n = 0;
			while (phase_n < 205) begin
				burst = $urandom_range(1, 24);
				for (int j = 0; j < burst && phase_n < 205; j++) begin
					send(rand_item());
					phase_n++;
				end
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 12));
			end
			sent += phase_n;
		end
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
